// ===== hdl/nau_pkg.sv =====
// shared types, constants and the feature row mapping for the nnue accumulator update block
package nau_pkg;

  // accumulator size and derived widths
  localparam int unsigned HIDDEN      = 128;
  localparam int unsigned HidW        = $clog2(HIDDEN);
  localparam int unsigned FeatureRows = 768;
  localparam int unsigned WDepth      = FeatureRows * HIDDEN;
  localparam int unsigned WAddrW      = $clog2(WDepth);

  // feature row layout
  localparam int unsigned ColorStride = 64 * 6;
  localparam int unsigned KindStride  = 64;
  localparam logic [5:0]  RankFlip    = 6'd56;
  localparam logic [2:0]  MaxKind     = 3'd5;

  localparam int unsigned ValW   = 16;
  localparam int unsigned FrowW  = 10;
  localparam int unsigned InTdW  = 48;
  localparam int unsigned OutTdW = 32;

  typedef enum logic [2:0] {
    CMD_WR_WEIGHT = 3'd0,
    CMD_WR_NEURON = 3'd1,
    CMD_ADD       = 3'd2,
    CMD_SUB       = 3'd3,
    CMD_RD_NEURON = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_DRAIN
  } state_e;

  // input item, last field in the lowest bits
  typedef struct packed {
    logic             pad;
    logic [ValW-1:0]  value;
    logic [FrowW-1:0] row;
    logic [6:0]       element;
    logic [5:0]       square;
    logic [2:0]       piece_kind;
    logic             piece_side;
    logic             perspective;
    logic [2:0]       cmd;
  } item_t;

  // weight memory port
  typedef struct packed {
    logic              we;
    logic [WAddrW-1:0] waddr;
    logic [ValW-1:0]   wdata;
    logic              re;
    logic [WAddrW-1:0] raddr;
  } wport_t;

  // neuron memory port
  typedef struct packed {
    logic            we;
    logic [HidW-1:0] waddr;
    logic [ValW-1:0] wdata;
    logic            re;
    logic [HidW-1:0] raddr;
  } nport_t;

  // result pushed towards the output queue
  typedef struct packed {
    logic             push;
    logic [FrowW-1:0] feature_row;
    logic [ValW-1:0]  read_value;
  } res_t;

  // feature row from colour, kind, square and perspective
  function automatic logic [FrowW-1:0] feature_row_f(logic pov, logic color,
                                                     logic [2:0] kind, logic [5:0] sq);
    logic [5:0]       vsq;
    logic [FrowW-1:0] off;
    vsq = pov ? (sq ^ RankFlip) : sq;
    off = (color != pov) ? FrowW'(ColorStride) : '0;
    return off + FrowW'(FrowW'(kind) * FrowW'(KindStride)) + FrowW'(vsq);
  endfunction

endpackage

// ===== hdl/nau_ram.sv =====
// generic simple dual-port ram with registered read
module nau_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/nau_ctrl.sv =====
// command sequencer: decode, row walk, read-modify-write of the accumulator
module nau_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  nau_pkg::item_t             item_i,
  input  logic                       room_i,
  output logic                       ready_o,
  output nau_pkg::wport_t            wport_o,
  output nau_pkg::nport_t            nport_o,
  input  logic [nau_pkg::ValW-1:0]   w_rdata_i,
  input  logic [nau_pkg::ValW-1:0]   n_rdata_i,
  output nau_pkg::res_t              res_o
);
  import nau_pkg::*;

  localparam logic [HidW-1:0] LastIdx = HidW'(HIDDEN - 1);

  state_e             state_q, state_d;
  logic [HidW-1:0]    idx_q, idx_d;
  logic [WAddrW-1:0]  base_q, base_d;
  logic [FrowW-1:0]   fr_q, fr_d;
  logic               sub_q, sub_d;
  logic               wr_vld_q;
  logic [HidW-1:0]    wr_idx_q;
  logic               nrd_vld_q;
  logic [HIDDEN-1:0]  nv_q;

  logic               accept;
  logic               elem_ok;
  logic [HidW-1:0]    elem_idx;
  logic [FrowW-1:0]   frow;
  logic [ValW-1:0]    nval;

  // field decode
  assign elem_ok  = 32'(item_i.element) < 32'(HIDDEN);
  assign elem_idx = HidW'(item_i.element);
  assign frow     = feature_row_f(item_i.perspective, item_i.piece_side,
                                  item_i.piece_kind, item_i.square);
  assign nval     = nrd_vld_q ? n_rdata_i : '0;
  assign ready_o  = (state_q == ST_IDLE) && room_i;
  assign accept   = valid_i && ready_o;

  // next state and memory control
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    base_d  = base_q;
    fr_d    = fr_q;
    sub_d   = sub_q;
    wport_o = '0;
    nport_o = '0;
    res_o   = '0;

    // write-back stage of the row walk
    if (wr_vld_q) begin
      nport_o.we    = 1'b1;
      nport_o.waddr = wr_idx_q;
      nport_o.wdata = sub_q ? (nval - w_rdata_i) : (nval + w_rdata_i);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(item_i.cmd)) inside
            CMD_WR_WEIGHT: begin
              if ((32'(item_i.row) < 32'(FeatureRows)) && elem_ok) begin
                wport_o.we    = 1'b1;
                wport_o.waddr = WAddrW'(WAddrW'(item_i.row) * WAddrW'(HIDDEN))
                                + WAddrW'(elem_idx);
                wport_o.wdata = item_i.value;
              end
              res_o.push = 1'b1;
            end
            CMD_WR_NEURON: begin
              if (elem_ok) begin
                nport_o.we    = 1'b1;
                nport_o.waddr = elem_idx;
                nport_o.wdata = item_i.value;
              end
              res_o.push = 1'b1;
            end
            CMD_ADD, CMD_SUB: begin
              if (item_i.piece_kind <= MaxKind) begin
                base_d  = WAddrW'(WAddrW'(frow) * WAddrW'(HIDDEN));
                fr_d    = frow;
                sub_d   = (cmd_e'(item_i.cmd) == CMD_SUB);
                idx_d   = '0;
                state_d = ST_WALK;
              end else begin
                res_o.push = 1'b1;
              end
            end
            CMD_RD_NEURON: begin
              nport_o.re    = elem_ok;
              nport_o.raddr = elem_ok ? elem_idx : '0;
              state_d       = ST_READ;
            end
            default: begin
              res_o.push = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_o.push       = 1'b1;
        res_o.read_value = nval;
        state_d          = ST_IDLE;
      end
      ST_WALK: begin
        wport_o.re    = 1'b1;
        wport_o.raddr = base_q + WAddrW'(idx_q);
        nport_o.re    = 1'b1;
        nport_o.raddr = idx_q;
        idx_d         = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        res_o.push        = 1'b1;
        res_o.feature_row = fr_q;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register and walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      wr_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      wr_vld_q <= (state_q == ST_WALK);
    end
  end

  // walk payload
  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    fr_q     <= fr_d;
    sub_q    <= sub_d;
    wr_idx_q <= idx_q;
  end

  // neuron valid bits, unwritten neurons read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q      <= '0;
      nrd_vld_q <= 1'b0;
    end else begin
      if (nport_o.we) begin
        nv_q[nport_o.waddr] <= 1'b1;
      end
      nrd_vld_q <= nport_o.re && nv_q[nport_o.raddr];
    end
  end

endmodule

// ===== hdl/nnue_accumulator_update.sv =====
// top level of the nnue accumulator update block: memories, sequencer and output queue
//
// Input stream (s_axis): one command per transfer: write a weight word, write a
// neuron, add or subtract a feature row into the accumulator, or read a neuron.
// Output stream (m_axis): exactly one result per input transfer, in order.
// A write or unused command, or an add or subtract with a piece kind past the
// king, pushes its result in the cycle of its transfer; a neuron read pushes it
// from a read state, any other add or subtract from a drain state after a walk
// over all HIDDEN entries (one weight word per cycle from the weight memory port,
// followed by a write-back of the accumulator entry the cycle after).
// One item is worked on at a time, so no new transfer is taken while a neuron
// read or such an add or subtract is still in progress.
// A two-entry output queue holds finished results: while one waits for the
// receiver, the next item is taken; with two waiting, s_axis_tready_o drops
// until the receiver takes one.
// Reset clears the accumulator at once through per-neuron valid bits; the
// weight memory is undefined until written.
module nnue_accumulator_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cmd[2:0], perspective[3], piece_side[4], piece_kind[7:5], square[13:8],
  // element[20:14], row[30:21], value[46:31], zero[47]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_value[15:0], feature_row[25:16], zero[31:26]
  output logic [31:0] m_axis_tdata_o
);
  import nau_pkg::*;

  localparam int unsigned ResW = ValW + FrowW;

  item_t           item;
  wport_t          wport;
  nport_t          nport;
  res_t            res;
  logic [ValW-1:0] w_rdata;
  logic [ValW-1:0] n_rdata;
  logic            room;
  logic            pop;

  logic [ResW-1:0] fifo_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;

  assign item = item_t'(s_axis_tdata_i);

  // weight memory
  nau_ram #(
    .WIDTH (ValW),
    .DEPTH (WDepth)
  ) u_wram (
    .clk_i   (clk_i),
    .we_i    (wport.we),
    .waddr_i (wport.waddr),
    .wdata_i (wport.wdata),
    .re_i    (wport.re),
    .raddr_i (wport.raddr),
    .rdata_o (w_rdata)
  );

  // accumulator memory
  nau_ram #(
    .WIDTH (ValW),
    .DEPTH (HIDDEN)
  ) u_nram (
    .clk_i   (clk_i),
    .we_i    (nport.we),
    .waddr_i (nport.waddr),
    .wdata_i (nport.wdata),
    .re_i    (nport.re),
    .raddr_i (nport.raddr),
    .rdata_o (n_rdata)
  );

  // sequencer
  nau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .item_i    (item),
    .room_i    (room),
    .ready_o   (s_axis_tready_o),
    .wport_o   (wport),
    .nport_o   (nport),
    .w_rdata_i (w_rdata),
    .n_rdata_i (n_rdata),
    .res_o     (res)
  );

  // two-entry output queue
  assign room            = (cnt_q != 2'd2);
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tdata_o  = {(OutTdW - ResW)'(0), fifo_q[rptr_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (res.push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      if (res.push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!res.push && pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.push) begin
      fifo_q[wptr_q] <= {res.feature_row, res.read_value};
    end
  end

  // a result is only pushed when the queue has space for it
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.push |-> (cnt_q != 2'd2 || pop))
    else $error("output queue overflow");

  // weight loads and row walks never share a cycle
  a_wport_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wport.we && wport.re))
    else $error("weight write during row walk");

  // write-back never hits the entry being read in the same cycle
  a_nport_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nport.we && nport.re) |-> (nport.waddr != nport.raddr))
    else $error("accumulator read and write collide");

  // an accepted add or subtract keeps the block busy in the following cycle
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && item.piece_kind <= MaxKind
     && (item.cmd == CMD_ADD || item.cmd == CMD_SUB))
    |=> (!s_axis_tready_o && !res.push))
    else $error("row walk did not start");

endmodule
